@@ rtl/sbck_pkg.sv @@
// Shared types and constants for the sprite blitter with clipping and color key.
// Used by sbck_front, sbck_queue, sbck_back and sprite_blit_clip_color_key_core.
package sbck_pkg;

  localparam int SCREEN_W_DEF       = 320;
  localparam int SCREEN_H_DEF       = 240;
  localparam int MAX_SPRITE_DIM_DEF = 256;

  localparam int CNT_W     = 8;   // sprite column / row counters
  localparam int COUNT_CAP = 256; // counter capacity
  localparam int POS_W     = 12;  // signed position and offset registers
  localparam int ANCH_W    = 8;
  localparam int DIM_W     = 9;
  localparam int COORD_W   = 14;  // signed screen coordinate, holds every sum
  localparam int COLOR_W   = 8;
  localparam int ADDR_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;
  localparam int QDEPTH    = 4;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRITE_POS_X = 3'd0,
    REG_SPRITE_POS_Y = 3'd1,
    REG_ANCHOR_OFF_X = 3'd2,
    REG_ANCHOR_OFF_Y = 3'd3,
    REG_VIEW_OFF_X   = 3'd4,
    REG_VIEW_OFF_Y   = 3'd5,
    REG_SPRITE_W     = 3'd6,
    REG_SPRITE_H     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] col_count;
    logic [CNT_W-1:0] row_count;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

@@ rtl/sprite_blit_clip_color_key_core.sv @@
// Top level of the sprite blitter with clipping and color key.
// Depends on sbck_pkg, sbck_front, sbck_queue and sbck_back.
//
// Takes one sprite art pixel per clock in row-major order and returns one
// framebuffer write word per pixel, at a sustained rate of one per clock
// while m_tready stays high. The front classifies a pixel in the cycle it is
// accepted (counters, screen position, clip, color key); a four-entry queue
// then feeds the back, whose single multiply-add forms row * SCREEN_W + column
// into the output register. The queue absorbs up to four words of downstream
// stall before s_tready drops. Configuration writes are always taken
// (cfg_ready is tied high) and act on the next pixel; they never reset the
// sprite counters.
module sprite_blit_clip_color_key_core #(
  parameter int SCREEN_W       = sbck_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H       = sbck_pkg::SCREEN_H_DEF,
  parameter int MAX_SPRITE_DIM = sbck_pkg::MAX_SPRITE_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sbck_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbck_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sbck_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] pixel_color
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] write_enable, [17:1] fb_address, [25:18] write_color, [31:26] zero
  output logic [sbck_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast   // last_pixel
);

  localparam int XW = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1;
  localparam int YW = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
  localparam int EW = XW + YW + sbck_pkg::COLOR_W + 2;
  localparam int DIM_LIM0 = (MAX_SPRITE_DIM < sbck_pkg::COUNT_CAP) ? MAX_SPRITE_DIM
                                                                   : sbck_pkg::COUNT_CAP;
  localparam int DIM_LIM  = (DIM_LIM0 < 1) ? 1 : DIM_LIM0;
  localparam int PAD_W = sbck_pkg::M_TDATA_W - 1 - sbck_pkg::ADDR_W - sbck_pkg::COLOR_W;

  logic                            push, pop;
  logic [EW-1:0]                   push_data, pop_data;
  sbck_pkg::front_stat_t           f_stat;
  sbck_pkg::queue_stat_t           q_stat;
  logic                            out_we;
  logic [sbck_pkg::ADDR_W-1:0]     out_addr;
  logic [sbck_pkg::COLOR_W-1:0]    out_color;

  assign cfg_ready = 1'b1;

  sbck_front #(
    .SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H), .MAX_SPRITE_DIM(MAX_SPRITE_DIM),
    .XW(XW), .YW(YW), .EW(EW)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_valid(s_tvalid), .pix_color(s_tdata[sbck_pkg::COLOR_W-1:0]),
    .q_full(q_stat.full), .pix_ready(s_tready),
    .push(push), .push_data(push_data), .stat(f_stat)
  );

  sbck_queue #(.WIDTH(EW), .DEPTH(sbck_pkg::QDEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .stat(q_stat)
  );

  sbck_back #(
    .SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H), .XW(XW), .YW(YW), .EW(EW)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_stat(q_stat), .pop_data(pop_data), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_we(out_we), .out_addr(out_addr), .out_color(out_color), .out_last(m_tlast)
  );

  assign m_tdata = {PAD_W'(0), out_color, out_addr, out_we};

  // dropped pixels must carry zero address and color
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_we) |-> (out_addr == '0 && out_color == '0))
    else $error("dropped pixel with nonzero address or color");

  // counters never run past the clamped sprite size limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (f_stat.col_count <= sbck_pkg::CNT_W'(DIM_LIM - 1)) &&
    (f_stat.row_count <= sbck_pkg::CNT_W'(DIM_LIM - 1)))
    else $error("sprite counter beyond size limit");

  // an accept into an idle path reaches the output through the queue and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && q_stat.empty && !m_tvalid) |=> ##1 m_tvalid)
    else $error("pixel lost between front and back");

  // the queue never pops while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule

@@ rtl/sbck_front.sv @@
// Front end: config registers, sprite counters, clipping and color-key test.
// Depends on sbck_pkg; pushes classified pixels into sbck_queue.
module sbck_front #(
  parameter int SCREEN_W       = sbck_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H       = sbck_pkg::SCREEN_H_DEF,
  parameter int MAX_SPRITE_DIM = sbck_pkg::MAX_SPRITE_DIM_DEF,
  parameter int XW             = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1,
  parameter int YW             = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1,
  parameter int EW             = XW + YW + sbck_pkg::COLOR_W + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [sbck_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbck_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           pix_valid,
  input  logic [sbck_pkg::COLOR_W-1:0]   pix_color,
  input  logic                           q_full,
  output logic                           pix_ready,
  output logic                           push,
  output logic [EW-1:0]                  push_data,
  output sbck_pkg::front_stat_t          stat
);

  localparam int DIM_LIM0 = (MAX_SPRITE_DIM < sbck_pkg::COUNT_CAP) ? MAX_SPRITE_DIM
                                                                   : sbck_pkg::COUNT_CAP;
  localparam int DIM_LIM  = (DIM_LIM0 < 1) ? 1 : DIM_LIM0;
  localparam int CW  = sbck_pkg::COORD_W;
  localparam int DW  = sbck_pkg::DIM_W;
  localparam int NW  = sbck_pkg::CNT_W;

  logic [sbck_pkg::POS_W-1:0]  sprite_pos_x, sprite_pos_y, view_off_x, view_off_y;
  logic [sbck_pkg::ANCH_W-1:0] anchor_off_x, anchor_off_y;
  logic [DW-1:0]               sprite_w, sprite_h;
  logic [NW-1:0]               col_count, row_count, col_count_next, row_count_next;

  logic [DW-1:0]        w_eff, h_eff;
  logic                 end_col, end_row, visible, we;
  logic signed [CW-1:0] sx, sy;
  logic [XW-1:0]        sx_v;
  logic [YW-1:0]        sy_v;
  logic [sbck_pkg::COLOR_W-1:0] color_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_pos_x <= '0;
      sprite_pos_y <= '0;
      anchor_off_x <= '0;
      anchor_off_y <= '0;
      view_off_x   <= '0;
      view_off_y   <= '0;
      sprite_w     <= DW'(1);
      sprite_h     <= DW'(1);
    end else if (cfg_valid) begin
      case (sbck_pkg::cfg_reg_t'(cfg_index))
        sbck_pkg::REG_SPRITE_POS_X: sprite_pos_x <= cfg_data;
        sbck_pkg::REG_SPRITE_POS_Y: sprite_pos_y <= cfg_data;
        sbck_pkg::REG_ANCHOR_OFF_X: anchor_off_x <= cfg_data[sbck_pkg::ANCH_W-1:0];
        sbck_pkg::REG_ANCHOR_OFF_Y: anchor_off_y <= cfg_data[sbck_pkg::ANCH_W-1:0];
        sbck_pkg::REG_VIEW_OFF_X:   view_off_x   <= cfg_data;
        sbck_pkg::REG_VIEW_OFF_Y:   view_off_y   <= cfg_data;
        sbck_pkg::REG_SPRITE_W:     sprite_w     <= cfg_data[DW-1:0];
        sbck_pkg::REG_SPRITE_H:     sprite_h     <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // size clamp: zero acts as one, large values saturate
  always_comb begin
    w_eff = sprite_w;
    if (sprite_w == '0) w_eff = DW'(1);
    else if (sprite_w > DW'(DIM_LIM)) w_eff = DW'(DIM_LIM);
    h_eff = sprite_h;
    if (sprite_h == '0) h_eff = DW'(1);
    else if (sprite_h > DW'(DIM_LIM)) h_eff = DW'(DIM_LIM);
  end

  assign end_col = {1'b0, col_count} >= (w_eff - DW'(1));
  assign end_row = {1'b0, row_count} >= (h_eff - DW'(1));

  assign sx = CW'($signed(sprite_pos_x)) - $signed(CW'(anchor_off_x))
            + CW'($signed(view_off_x)) + $signed(CW'(col_count));
  assign sy = CW'($signed(sprite_pos_y)) - $signed(CW'(anchor_off_y))
            + CW'($signed(view_off_y)) + $signed(CW'(row_count));

  assign visible = (sx >= 0) && (sx < $signed(CW'(SCREEN_W)))
                && (sy >= 0) && (sy < $signed(CW'(SCREEN_H)));
  assign we = visible && (pix_color != '0);

  // dropped pixels carry zero address and color
  assign sx_v    = we ? sx[XW-1:0] : '0;
  assign sy_v    = we ? sy[YW-1:0] : '0;
  assign color_v = we ? pix_color : '0;

  assign pix_ready = !q_full;
  assign push      = pix_valid && pix_ready;
  assign push_data = {end_col && end_row, we, color_v, sy_v, sx_v};

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (push) begin
      if (end_col) begin
        col_count_next = '0;
        row_count_next = end_row ? '0 : row_count + NW'(1);
      end else begin
        col_count_next = col_count + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  assign stat.col_count = col_count;
  assign stat.row_count = row_count;

endmodule

@@ rtl/sbck_queue.sv @@
// Short FIFO between the front classifier and the back address stage.
// Depends on sbck_pkg for the status struct.
module sbck_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sbck_pkg::QDEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output sbck_pkg::queue_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    fill;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   fill <= fill + NW'(1);
        2'b01:   fill <= fill - NW'(1);
        default: fill <= fill;
      endcase
    end
  end

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (fill == NW'(DEPTH));
  assign stat.empty = (fill == '0);

endmodule

@@ rtl/sbck_back.sv @@
// Back end: framebuffer address multiply-add and output register.
// Depends on sbck_pkg; drains entries from sbck_queue.
module sbck_back #(
  parameter int SCREEN_W = sbck_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = sbck_pkg::SCREEN_H_DEF,
  parameter int XW       = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1,
  parameter int YW       = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1,
  parameter int EW       = XW + YW + sbck_pkg::COLOR_W + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sbck_pkg::queue_stat_t         q_stat,
  input  logic [EW-1:0]                 pop_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_we,
  output logic [sbck_pkg::ADDR_W-1:0]   out_addr,
  output logic [sbck_pkg::COLOR_W-1:0]  out_color,
  output logic                          out_last
);

  localparam int PROD_W = XW + YW;
  localparam int CLW    = sbck_pkg::COLOR_W;

  logic [XW-1:0]     sx;
  logic [YW-1:0]     sy;
  logic [CLW-1:0]    color;
  logic              we, last;
  logic [PROD_W-1:0] lin;

  assign {last, we, color, sy, sx} = pop_data;

  // row * width + column; clipped coordinates keep this below 2^PROD_W
  assign lin = PROD_W'(sy) * PROD_W'(SCREEN_W) + PROD_W'(sx);

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_we    <= we;
      out_addr  <= sbck_pkg::ADDR_W'(lin);
      out_color <= color;
      out_last  <= last;
    end
  end

endmodule

@@ verif/tb_sprite_blit_clip_color_key_core.sv @@
// Testbench for sprite_blit_clip_color_key_core: art pixels in, framebuffer write words out.
// Predicts every write word from its own copy of the registers and counters.
// Depends on sbck_pkg and the RTL of the core.
module tb_sprite_blit_clip_color_key_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                         we;
    logic [sbck_pkg::ADDR_W-1:0]  addr;
    logic [sbck_pkg::COLOR_W-1:0] color;
    logic                         last;
  } fb_write_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sbck_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sbck_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sbck_pkg::S_TDATA_W-1:0] s_tdata = '0;     // [7:0] pixel_color
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // [0] we, [17:1] addr, [25:18] color, [31:26] zero
  logic [sbck_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tlast;          // last_pixel

  // register and counter mirror
  logic [sbck_pkg::POS_W-1:0]  pos_x_q = '0, pos_y_q = '0, view_x_q = '0, view_y_q = '0;
  logic [sbck_pkg::ANCH_W-1:0] anc_x_q = '0, anc_y_q = '0;
  logic [sbck_pkg::DIM_W-1:0]  width_q = sbck_pkg::DIM_W'(1), height_q = sbck_pkg::DIM_W'(1);
  logic [sbck_pkg::CNT_W-1:0]  col_pos = '0, row_pos = '0;

  fb_write_t pending_writes[$];
  int        mismatches = 0;
  logic      no_gaps = 1'b0;

  sprite_blit_clip_color_key_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= 7);
  end

  function automatic int size_in_effect(logic [sbck_pkg::DIM_W-1:0] d);
    int lim;
    lim = (sbck_pkg::MAX_SPRITE_DIM_DEF < sbck_pkg::COUNT_CAP) ? sbck_pkg::MAX_SPRITE_DIM_DEF
                                                               : sbck_pkg::COUNT_CAP;
    if (d == 0) return 1;
    if (int'(d) > lim) return lim;
    return int'(d);
  endfunction

  // one art pixel -> one write word; advances the sprite counters
  function automatic fb_write_t blit_pixel(logic [sbck_pkg::COLOR_W-1:0] color);
    fb_write_t r;
    int   w, h, px, py, sx, sy;
    logic end_col, end_row, visible;
    w = size_in_effect(width_q);
    h = size_in_effect(height_q);
    // a counter past a freshly lowered size counts as the last column/row
    end_col = int'(col_pos) >= w - 1;
    end_row = int'(row_pos) >= h - 1;
    px = int'($signed(pos_x_q)) - int'(anc_x_q) + int'($signed(view_x_q));
    py = int'($signed(pos_y_q)) - int'(anc_y_q) + int'($signed(view_y_q));
    sx = px + int'(col_pos);
    sy = py + int'(row_pos);
    visible = sx >= 0 && sx < sbck_pkg::SCREEN_W_DEF && sy >= 0 && sy < sbck_pkg::SCREEN_H_DEF;
    r.we    = visible && color != 0;
    r.addr  = r.we ? sbck_pkg::ADDR_W'(sy * sbck_pkg::SCREEN_W_DEF + sx) : '0;
    r.color = r.we ? color : '0;
    r.last  = end_col && end_row;
    if (end_col) begin
      col_pos = '0;
      row_pos = end_row ? '0 : row_pos + sbck_pkg::CNT_W'(1);
    end else begin
      col_pos = col_pos + sbck_pkg::CNT_W'(1);
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_writes
    fb_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        flag_error($sformatf("write word %h with nothing pending", m_tdata));
      end else begin
        want = pending_writes.pop_front();
        if (m_tdata[0] !== want.we || m_tdata[17:1] !== want.addr ||
            m_tdata[25:18] !== want.color || m_tdata[31:26] !== 6'b0 ||
            m_tlast !== want.last) begin
          flag_error($sformatf(
            {"expected we=%0b addr=%0d color=%0h last=%0b, ",
             "got we=%0b addr=%0d color=%0h last=%0b pad=%0h"},
            want.we, want.addr, want.color, want.last,
            m_tdata[0], m_tdata[17:1], m_tdata[25:18], m_tlast, m_tdata[31:26]));
        end
      end
    end
  end

  task automatic push_pixel(input logic [sbck_pkg::COLOR_W-1:0] color);
    while (!no_gaps && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= color;
    do @(posedge clk); while (!s_tready);
    pending_writes.push_back(blit_pixel(color));
  endtask

  task automatic drain_writes();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic write_reg(input sbck_pkg::cfg_reg_t idx, input int value);
    logic [sbck_pkg::CFG_DAT_W-1:0] v;
    v = sbck_pkg::CFG_DAT_W'(value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sbck_pkg::REG_SPRITE_POS_X: pos_x_q  = v[sbck_pkg::POS_W-1:0];
      sbck_pkg::REG_SPRITE_POS_Y: pos_y_q  = v[sbck_pkg::POS_W-1:0];
      sbck_pkg::REG_ANCHOR_OFF_X: anc_x_q  = v[sbck_pkg::ANCH_W-1:0];
      sbck_pkg::REG_ANCHOR_OFF_Y: anc_y_q  = v[sbck_pkg::ANCH_W-1:0];
      sbck_pkg::REG_VIEW_OFF_X:   view_x_q = v[sbck_pkg::POS_W-1:0];
      sbck_pkg::REG_VIEW_OFF_Y:   view_y_q = v[sbck_pkg::POS_W-1:0];
      sbck_pkg::REG_SPRITE_W:     width_q  = v[sbck_pkg::DIM_W-1:0];
      sbck_pkg::REG_SPRITE_H:     height_q = v[sbck_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  // waits for the pipe to empty, then rewrites every register
  task automatic load_sprite(input int pos_x, input int pos_y, input int anc_x, input int anc_y,
                             input int view_x, input int view_y, input int raw_w, input int raw_h);
    drain_writes();
    write_reg(sbck_pkg::REG_SPRITE_POS_X, pos_x);
    write_reg(sbck_pkg::REG_SPRITE_POS_Y, pos_y);
    write_reg(sbck_pkg::REG_ANCHOR_OFF_X, anc_x);
    write_reg(sbck_pkg::REG_ANCHOR_OFF_Y, anc_y);
    write_reg(sbck_pkg::REG_VIEW_OFF_X, view_x);
    write_reg(sbck_pkg::REG_VIEW_OFF_Y, view_y);
    write_reg(sbck_pkg::REG_SPRITE_W, raw_w);
    write_reg(sbck_pkg::REG_SPRITE_H, raw_h);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [sbck_pkg::COLOR_W-1:0] rand_color();
    return ($urandom_range(3) == 0) ? '0 : sbck_pkg::COLOR_W'($urandom_range(255));
  endfunction

  // reset registers: 1x1 sprite at the origin, every pixel is the last one
  task automatic test_reset_defaults();
    push_pixel(8'h00);
    push_pixel(8'h01);
    push_pixel(8'h80);
    push_pixel(8'hFF);
  endtask

  // shrink the sprite while the counters sit past the new last column and row
  task automatic test_size_shrink();
    load_sprite(10, 20, 0, 0, 0, 0, 4, 4);
    repeat (6) push_pixel(8'h5A);
    load_sprite(10, 20, 0, 0, 0, 0, 2, 1);
    push_pixel(8'h3C);
    push_pixel(8'hC3);
    push_pixel(8'h7E);
  endtask

  task automatic test_screen_corners();
    // only the top-left pixel lands, on the very last framebuffer address
    load_sprite(319, 239, 0, 0, 0, 0, 2, 2);
    push_pixel(8'hFF);
    push_pixel(8'h01);
    push_pixel(8'h00);
    push_pixel(8'hAA);
    // sprite starts at (-1,-1): only its bottom-right pixel lands, at address 0
    load_sprite(2047, -2048, 0, 0, -2048, 2047, 2, 2);
    push_pixel(8'h11);
    push_pixel(8'h22);
    push_pixel(8'h33);
    push_pixel(8'h80);
  endtask

  // far off screen; width 0 acts as 1, height 4095 keeps 511 and saturates
  task automatic test_extremes();
    load_sprite(2047, -2048, 255, 255, 2047, -2048, 0, 4095);
    push_pixel(8'hFF);
    push_pixel(8'h01);
    push_pixel(8'h00);
  endtask

  task automatic test_burst_no_gaps();
    load_sprite(100, 50, 4, 2, -3, 7, 16, 8);
    no_gaps <= 1'b1;
    repeat (128) push_pixel(rand_color());
    drain_writes();
    no_gaps <= 1'b0;
  endtask

  task automatic test_random_sprites();
    int sent, kind, raw_w, raw_h, ew, eh, px, py, ax, ay, vx, vy, n;
    sent = 0;
    while (sent < 560) begin
      kind  = $urandom_range(29);
      raw_w = $urandom_range(1, 12);
      raw_h = $urandom_range(1, 6);
      if (kind == 0) begin
        raw_w = $urandom_range(4095);
        raw_h = $urandom_range(4095);
      end else if (kind == 1) begin
        raw_w = 256;
        raw_h = 1;
      end
      ew = size_in_effect(sbck_pkg::DIM_W'(raw_w));
      eh = size_in_effect(sbck_pkg::DIM_W'(raw_h));
      ax = $urandom_range(255);
      ay = $urandom_range(255);
      if (kind <= 4 && kind != 1) begin
        px = int'($urandom_range(4095)) - 2048;
        py = int'($urandom_range(4095)) - 2048;
        vx = int'($urandom_range(4095)) - 2048;
        vy = int'($urandom_range(4095)) - 2048;
      end else begin
        // place the sprite so that it overlaps the screen edges or lies just beyond them
        vx = int'($urandom_range(2800)) - 1400;
        vy = int'($urandom_range(2800)) - 1400;
        px = int'($urandom_range(sbck_pkg::SCREEN_W_DEF + ew + 4)) - ew - 2 + ax - vx;
        py = int'($urandom_range(sbck_pkg::SCREEN_H_DEF + eh + 4)) - eh - 2 + ay - vy;
      end
      load_sprite(px, py, ax, ay, vx, vy, raw_w, raw_h);
      if (kind == 1) n = ew * eh;
      else if (ew * eh <= 64 && $urandom_range(3) != 0) n = ew * eh * $urandom_range(1, 2);
      else n = $urandom_range(1, 40);
      repeat (n) push_pixel(rand_color());
      sent += n;
    end
    drain_writes();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_size_shrink();
    test_screen_corners();
    test_extremes();
    test_burst_no_gaps();
    test_random_sprites();
    drain_writes();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sbck_pkg.sv
rtl/sbck_front.sv
rtl/sbck_queue.sv
rtl/sbck_back.sv
rtl/sprite_blit_clip_color_key_core.sv
verif/tb_sprite_blit_clip_color_key_core.sv
